// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LFU key/value cache: transfer payloads,
// the stored entry word and the compare unit result.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KeyW   = 32;
  localparam int ValW   = 31;
  localparam int CntW   = 32;
  localparam int StampW = 64;
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [CntW-1:0] CountMax = '1;

  // action codes
  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  typedef struct packed {
    logic                   action;
    logic signed [KeyW-1:0] lookup_key;
    logic [ValW-1:0]        write_value;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic [ValW-1:0]        read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } out_item_t;

  // one stored entry, kept as a single RAM word
  typedef struct packed {
    logic [KeyW-1:0]   ent_key;
    logic [ValW-1:0]   ent_value;
    logic [CntW-1:0]   use_count;
    logic [StampW-1:0] last_touch;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // compare unit result
  typedef struct packed {
    logic key_eq;
    logic better;
  } cmp_res_t;

endpackage

// ===== rtl/core/lkvc_ram.sv =====
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/lkvc_cmp.sv =====
// ----------------------------------------------------------------------------
// lkvc_cmp
// Shared compare unit: key match and victim order (lower use count, then
// older last touch) for the entry read in the current scan step.
// ----------------------------------------------------------------------------
module lkvc_cmp (
  input  lkvc_pkg::entry_t              entry_i,
  input  logic [lkvc_pkg::KeyW-1:0]     probe_key_i,
  input  logic [lkvc_pkg::CntW-1:0]     best_count_i,
  input  logic [lkvc_pkg::StampW-1:0]   best_touch_i,
  output lkvc_pkg::cmp_res_t            res_o
);

  logic cnt_lt;
  logic cnt_eq;
  logic touch_lt;

  // magnitude compares
  assign cnt_lt   = entry_i.use_count < best_count_i;
  assign cnt_eq   = entry_i.use_count == best_count_i;
  assign touch_lt = entry_i.last_touch < best_touch_i;

  assign res_o.key_eq = entry_i.ent_key == probe_key_i;
  assign res_o.better = cnt_lt | (cnt_eq & touch_lt);

endmodule

// ===== rtl/core/lfu_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lfu_key_value_cache_top
// LFU key/value cache, sequential scan of an entry RAM with one compare unit.
// ----------------------------------------------------------------------------
// Sequence: an item is taken in the idle state; the scan state then reads the
//   single-read-port entry RAM one entry at a time, the write state writes back
//   and the done state loads the output register; input stalls outside idle.
// Reset: valid bits, access clock and control clear at once; capacity resets
//   to 16; entry RAM contents are not cleared and no clearing pass is needed.
module lfu_key_value_cache_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lkvc_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lkvc_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]   cfg_data_i
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CW > lkvc_pkg::CapW) ? CW : lkvc_pkg::CapW;
  localparam logic [CW-1:0] LastCnt = CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StDone
  } state_e;

  state_e                          state_q;
  logic [lkvc_pkg::CapW-1:0]       cap_q;
  logic [lkvc_pkg::StampW-1:0]     clock_q;
  logic [MAX_ENTRIES-1:0]          valid_q;
  lkvc_pkg::in_item_t              item_q;
  logic [CW-1:0]                   cnt_q;

  // scan results
  logic                            hit_q;
  logic [IdxW-1:0]                 hit_idx_q;
  lkvc_pkg::entry_t                hit_ent_q;
  logic                            vic_found_q;
  logic [IdxW-1:0]                 vic_idx_q;
  logic [lkvc_pkg::CntW-1:0]       vic_cnt_q;
  logic [lkvc_pkg::StampW-1:0]     vic_touch_q;
  logic [lkvc_pkg::KeyW-1:0]       vic_key_q;
  logic                            free_found_q;
  logic [IdxW-1:0]                 free_idx_q;
  logic [CW-1:0]                   used_q;

  lkvc_pkg::out_item_t             res_q;
  logic                            out_valid_q;
  lkvc_pkg::out_item_t             out_q;

  lkvc_pkg::entry_t                rd_ent;
  lkvc_pkg::cmp_res_t              cmp_res;
  logic [IdxW-1:0]                 eval_idx;
  logic                            eval_en;
  logic                            eval_valid;

  logic                            ram_we;
  logic [IdxW-1:0]                 ram_waddr;
  lkvc_pkg::entry_t                ram_wdata;

  // write-back decisions
  logic [CmpW-1:0]                 cap_eff;
  logic                            cap_zero;
  logic                            full;
  logic                            do_evict;
  logic                            slot_ok;
  logic [IdxW-1:0]                 slot_idx;
  logic                            touched;
  logic [lkvc_pkg::CntW-1:0]       hit_cnt_inc;
  lkvc_pkg::out_item_t             res_d;
  logic [MAX_ENTRIES-1:0]          valid_d;
  logic                            out_load;
  logic                            out_valid_d;

  // entry storage
  lkvc_ram #(
    .Width (lkvc_pkg::EntryW),
    .Depth (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd_ent)
  );

  // shared compare unit
  lkvc_cmp u_cmp (
    .entry_i      (rd_ent),
    .probe_key_i  (item_q.lookup_key),
    .best_count_i (vic_cnt_q),
    .best_touch_i (vic_touch_q),
    .res_o        (cmp_res)
  );

  // entry under evaluation is the one addressed in the previous cycle
  assign eval_idx   = IdxW'(cnt_q - CW'(1));
  assign eval_en    = (state_q == StScan) && (cnt_q != '0);
  assign eval_valid = valid_q[eval_idx];

  // write-back and result
  always_comb begin
    cap_eff = (CmpW'(cap_q) > CmpW'(MAX_ENTRIES)) ? CmpW'(MAX_ENTRIES) : CmpW'(cap_q);
    cap_zero = (cap_eff == '0);
    full     = CmpW'(used_q) >= cap_eff;
    do_evict = 1'b0;
    slot_ok  = 1'b0;
    slot_idx = free_idx_q;
    touched  = 1'b0;
    hit_cnt_inc = (hit_ent_q.use_count == lkvc_pkg::CountMax) ? hit_ent_q.use_count
                                                               : hit_ent_q.use_count + 1'b1;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = hit_ent_q;
    ram_wdata.use_count  = hit_cnt_inc;
    ram_wdata.last_touch = clock_q;
    res_d = '0;

    if (item_q.action == lkvc_pkg::ActGet) begin
      if (hit_q) begin
        touched          = 1'b1;
        res_d.hit        = 1'b1;
        res_d.read_value = hit_ent_q.ent_value;
      end
    end else if (!cap_zero) begin
      if (hit_q) begin
        touched             = 1'b1;
        res_d.hit           = 1'b1;
        ram_wdata.ent_value = item_q.write_value;
      end else begin
        do_evict = full && vic_found_q;
        if (do_evict && (!free_found_q || (vic_idx_q < free_idx_q))) begin
          slot_idx = vic_idx_q;
        end
        slot_ok   = do_evict || free_found_q;
        touched   = slot_ok;
        ram_waddr = slot_idx;
        ram_wdata.ent_key    = item_q.lookup_key;
        ram_wdata.ent_value  = item_q.write_value;
        ram_wdata.use_count  = lkvc_pkg::CntW'(1);
        res_d.evicted        = do_evict;
        res_d.evicted_key    = do_evict ? vic_key_q : '0;
      end
    end
    ram_we = (state_q == StWrite) && touched;

    // valid bits after eviction and insert
    valid_d = valid_q;
    if (state_q == StWrite) begin
      if (do_evict) begin
        valid_d[vic_idx_q] = 1'b0;
      end
      if (slot_ok) begin
        valid_d[slot_idx] = 1'b1;
      end
    end

    // output register load and transfer
    out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // sequencer, scan bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cap_q        <= lkvc_pkg::CapReset;
      clock_q      <= '0;
      valid_q      <= '0;
      item_q       <= '0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_ent_q    <= '0;
      vic_found_q  <= 1'b0;
      vic_idx_q    <= '0;
      vic_cnt_q    <= '0;
      vic_touch_q  <= '0;
      vic_key_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      used_q       <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end

      // output transfer
      out_valid_q <= out_valid_d;

      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            item_q       <= in_data_i;
            cnt_q        <= '0;
            hit_q        <= 1'b0;
            vic_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            used_q       <= '0;
            state_q      <= StScan;
          end
        end

        StScan: begin
          if (eval_en) begin
            if (eval_valid) begin
              used_q <= used_q + 1'b1;
              if (cmp_res.key_eq && !hit_q) begin
                hit_q     <= 1'b1;
                hit_idx_q <= eval_idx;
                hit_ent_q <= rd_ent;
              end
              if (!vic_found_q || cmp_res.better) begin
                vic_found_q <= 1'b1;
                vic_idx_q   <= eval_idx;
                vic_cnt_q   <= rd_ent.use_count;
                vic_touch_q <= rd_ent.last_touch;
                vic_key_q   <= rd_ent.ent_key;
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= eval_idx;
            end
          end
          if (cnt_q == LastCnt) begin
            state_q <= StWrite;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        StWrite: begin
          valid_q <= valid_d;
          if (touched) begin
            clock_q <= clock_q + 1'b1;
          end
          res_q   <= res_d;
          state_q <= StDone;
        end

        StDone: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
